// ----- rtl/wake_vote_sleep_debounce_ctrl_core_macros.svh -----
`ifndef WAKE_VOTE_SLEEP_DEBOUNCE_CTRL_CORE_MACROS_SVH
`define WAKE_VOTE_SLEEP_DEBOUNCE_CTRL_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WVSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wvsd check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WVSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wvsd check failed");

`endif

// ----- rtl/wvsd_pkg.sv -----
`default_nettype none
package wvsd_pkg;

   localparam int NUM_USERS   = 8;
   localparam int DELAY_WIDTH = 16;

   localparam int FUNC_W      = 3;
   localparam int USER_W      = 3;
   localparam int MASK_W      = 8;
   localparam int CNT_W       = 32;
   localparam int CFG_DELAY_W = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CFG_DELAY_W-1:0] DEFAULT_DELAY = CFG_DELAY_W'(30);
   localparam longint unsigned DELAY_MAX = (64'd1 << DELAY_WIDTH) - 64'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT    = 3'd0,
      FUNC_CLEAR   = 3'd1,
      FUNC_JOIN    = 3'd2,
      FUNC_RELEASE = 3'd3,
      FUNC_SETCHK  = 3'd4,
      FUNC_TICK    = 3'd5,
      FUNC_DEINIT  = 3'd6
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLEEP_DELAY = 1'd0,
      CSR_TIMER_EN    = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [CFG_DELAY_W-1:0] sleep_delay_ticks;
      logic                   delay_timer_enable;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [USER_W-1:0] user;
      logic              hw_clear_ok;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic              notify_set;
      logic              hw_clear_cmd;
      logic              hw_set_cmd;
      logic              asleep;
      logic [MASK_W-1:0] holder_mask;
      logic              wake_failed;
   } rsp_type;

   // One-hot bit of a user; an index at or above NUM_USERS has no bit.
   function automatic logic [NUM_USERS-1:0] user_bit(input logic [USER_W-1:0] u);
      logic [NUM_USERS-1:0] res;
      res = '0;
      for (int i = 0; i < NUM_USERS; i++) begin
         res[i] = (32'(u) == 32'(i));
      end
      return res;
   endfunction

   function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [CFG_DELAY_W-1:0] d);
      logic [DELAY_WIDTH-1:0] res;
      if (64'(d) > DELAY_MAX) begin
         res = '1;
      end else begin
         res = DELAY_WIDTH'(d);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/wake_vote_sleep_debounce_ctrl_core.sv -----
// A request passes through the input register and then the result register before its result appears on rsp_.
// Throughput: one request per cycle while rsp_tready holds; the input register and the result register
// each take a new item whenever the stage after them drains in the same cycle.
// Reset (synchronous, active high) empties both registers, clears all vote state
// and loads the configuration defaults: 30 debounce ticks, countdown enabled.
`default_nettype none
`include "wake_vote_sleep_debounce_ctrl_core_macros.svh"
module wake_vote_sleep_debounce_ctrl_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [2:0] user, [3] hw_clear_ok, [7:4] zero
   input  wire logic [wvsd_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] func
   input  wire logic [wvsd_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] ok, [1] notify_set, [2] hw_clear_cmd, [3] hw_set_cmd, [4] asleep,
   // [12:5] holder_mask, [13] wake_failed, [15:14] zero
   output logic [wvsd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [wvsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [wvsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wvsd_pkg::*;

   cfg_type cfg;
   req_type req_item;
   req_type held_item;
   rsp_type result;
   rsp_type out_held;
   logic    req_accept;
   logic    advance;
   logic    held_valid;
   logic    out_space;

   assign req_accept           = req_tvalid && req_tready;
   assign req_item.func        = req_tuser;
   assign req_item.user        = req_tdata[USER_W-1:0];
   assign req_item.hw_clear_ok = req_tdata[USER_W];

   wvsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wvsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_item),
      .down_ready (out_space),
      .in_ready   (req_tready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   wvsd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (held_item),
      .result  (result)
   );

   wvsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .space      (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .held       (out_held)
   );

   // A sleep command always leaves the core asleep.
   `WVSD_ASSERT_NOW(a_set_means_asleep, clock, reset, rsp_tvalid && out_held.hw_set_cmd, out_held.asleep)
   // A successful wake always leaves the core awake.
   `WVSD_ASSERT_NOW(a_wake_means_awake, clock, reset, rsp_tvalid && out_held.hw_clear_cmd && out_held.ok, !out_held.asleep)
   // A request that cannot move on stays in the input register.
   `WVSD_ASSERT_NEXT(a_stalled_item_kept, clock, reset, held_valid && !advance, held_valid)

endmodule
`default_nettype wire

// ----- rtl/wvsd_csr.sv -----
`default_nettype none
module wvsd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [wvsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wvsd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output wvsd_pkg::cfg_type                    cfg
);
   import wvsd_pkg::*;

   logic [CFG_DELAY_W-1:0] delay_ff, delay_in;
   logic                   timer_en_ff, timer_en_in;

   always_comb begin
      delay_in    = delay_ff;
      timer_en_in = timer_en_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SLEEP_DELAY: delay_in    = CFG_DELAY_W'(csr_wdata);
            CSR_TIMER_EN:    timer_en_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DEFAULT_DELAY;
         timer_en_ff <= 1'b1;
      end else begin
         delay_ff    <= delay_in;
         timer_en_ff <= timer_en_in;
      end
   end

   assign cfg.sleep_delay_ticks  = delay_ff;
   assign cfg.delay_timer_enable = timer_en_ff;

endmodule
`default_nettype wire

// ----- rtl/wvsd_in_reg.sv -----
`default_nettype none
module wvsd_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_accept,
   input  wire wvsd_pkg::req_type req_item,
   input  wire logic              down_ready,
   output logic                   in_ready,
   output logic                   advance,
   output logic                   held_valid,
   output wvsd_pkg::req_type      held_item
);
   import wvsd_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff,  item_in;

   assign advance  = valid_ff && down_ready;
   assign in_ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_accept) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule
`default_nettype wire

// ----- rtl/wvsd_engine.sv -----
`default_nettype none
module wvsd_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wvsd_pkg::cfg_type cfg,
   input  wire logic              step_en,
   input  wire wvsd_pkg::req_type item,
   output wvsd_pkg::rsp_type      result
);
   import wvsd_pkg::*;

   logic                   active_ff,   active_in;
   logic                   fw_owned_ff, fw_owned_in;
   logic                   notified_ff, notified_in;
   logic                   fail_ff,     fail_in;
   logic [NUM_USERS-1:0]   holders_ff,  holders_in;
   logic [CNT_W-1:0]       cc_ff,       cc_in;
   logic [CNT_W-1:0]       ccn_ff,      ccn_in;
   logic [DELAY_WIDTH-1:0] cd_ff,       cd_in;
   logic                   run_ff,      run_in;

   always_comb begin
      logic [NUM_USERS-1:0] ubit;
      logic [NUM_USERS-1:0] left;
      logic                 wake_needed;
      logic                 good;
      logic                 arrange;
      logic                 now;
      logic                 ok, ntf, clr_cmd, set_cmd;

      ubit        = user_bit(item.user);
      left        = holders_ff & ~ubit;
      wake_needed = 1'b0;
      good        = 1'b1;
      arrange     = 1'b0;
      ok          = 1'b0;
      ntf         = 1'b0;
      clr_cmd     = 1'b0;
      set_cmd     = 1'b0;
      now         = !cfg.delay_timer_enable || (cfg.sleep_delay_ticks == '0);

      active_in   = active_ff;
      fw_owned_in = fw_owned_ff;
      notified_in = notified_ff;
      fail_in     = fail_ff;
      holders_in  = holders_ff;
      cc_in       = cc_ff;
      ccn_in      = ccn_ff;
      cd_in       = cd_ff;
      run_in      = run_ff;

      unique case (func_type'(item.func))
         FUNC_INIT: begin
            active_in   = 1'b1;
            notified_in = 1'b0;
            fw_owned_in = 1'b0;
            fail_in     = 1'b0;
            holders_in  = ubit;
            cc_in       = CNT_W'(1);
            ccn_in      = CNT_W'(1);
         end
         FUNC_CLEAR: begin
            if (active_ff) begin
               // A wake is only needed when nobody holds the core and it sleeps.
               if (fail_ff) begin
                  good = 1'b0;
               end else if ((holders_ff == '0) && fw_owned_ff) begin
                  wake_needed = 1'b1;
                  clr_cmd     = 1'b1;
                  good        = item.hw_clear_ok;
               end
               if (!wake_needed || good) begin
                  cc_in      = cc_ff + CNT_W'(1);
                  holders_in = holders_ff | ubit;
               end
               if (wake_needed && good) begin
                  fw_owned_in = 1'b0;
               end
               if (wake_needed && !good) begin
                  fail_in = 1'b1;
               end
               ok = good;
            end
         end
         FUNC_JOIN: begin
            if (active_ff && !fw_owned_ff) begin
               holders_in = holders_ff | ubit;
               cc_in      = cc_ff + CNT_W'(1);
               ok         = 1'b1;
            end
         end
         FUNC_RELEASE: begin
            if (active_ff) begin
               holders_in = left;
               if (!notified_ff && (left == '0)) begin
                  ccn_in      = cc_ff;
                  notified_in = 1'b1;
                  ok          = 1'b1;
                  arrange     = 1'b1;
               end
            end
         end
         FUNC_SETCHK: begin
            if (active_ff) begin
               // A clear or join since the notification re-arms it instead of sleeping.
               if ((cc_ff != ccn_ff) && notified_ff && (holders_ff == '0)) begin
                  ccn_in  = cc_ff;
                  arrange = 1'b1;
               end else begin
                  if (!fw_owned_ff && (holders_ff == '0)) begin
                     fw_owned_in = 1'b1;
                     set_cmd     = 1'b1;
                  end
                  notified_in = 1'b0;
               end
            end
         end
         FUNC_TICK: begin
            if (run_ff) begin
               if (cd_ff <= DELAY_WIDTH'(1)) begin
                  cd_in  = '0;
                  run_in = 1'b0;
                  ntf    = 1'b1;
               end else begin
                  cd_in = cd_ff - DELAY_WIDTH'(1);
               end
            end
         end
         FUNC_DEINIT: begin
            if (cfg.delay_timer_enable) begin
               cd_in  = '0;
               run_in = 1'b0;
            end
            active_in = 1'b0;
         end
         default: ;
      endcase

      if (arrange) begin
         if (now) begin
            ntf = 1'b1;
         end else begin
            cd_in  = sat_delay(cfg.sleep_delay_ticks);
            run_in = 1'b1;
         end
      end

      result.ok           = ok;
      result.notify_set   = ntf;
      result.hw_clear_cmd = clr_cmd;
      result.hw_set_cmd   = set_cmd;
      result.asleep       = fw_owned_in;
      result.holder_mask  = MASK_W'(holders_in);
      result.wake_failed  = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         fw_owned_ff <= 1'b0;
         notified_ff <= 1'b0;
         fail_ff     <= 1'b0;
         holders_ff  <= '0;
         cc_ff       <= '0;
         ccn_ff      <= '0;
         cd_ff       <= '0;
         run_ff      <= 1'b0;
      end else if (step_en) begin
         active_ff   <= active_in;
         fw_owned_ff <= fw_owned_in;
         notified_ff <= notified_in;
         fail_ff     <= fail_in;
         holders_ff  <= holders_in;
         cc_ff       <= cc_in;
         ccn_ff      <= ccn_in;
         cd_ff       <= cd_in;
         run_ff      <= run_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/wvsd_out_reg.sv -----
`default_nettype none
module wvsd_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire wvsd_pkg::rsp_type                 result,
   output logic                                   space,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [wvsd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output wvsd_pkg::rsp_type                      held
);
   import wvsd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({data_ff.wake_failed, data_ff.holder_mask,
                                     data_ff.asleep, data_ff.hw_set_cmd,
                                     data_ff.hw_clear_cmd, data_ff.notify_set,
                                     data_ff.ok});
   assign held       = data_ff;

endmodule
`default_nettype wire
